// File: src/poi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

  // Field widths of the request and response channels
  localparam int unsigned VEL_W  = 16;
  localparam int unsigned DT_W   = 20;
  localparam int unsigned POSE_W = 48;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned QUAT_W = 16;

  // Stored position width and CORDIC step count
  localparam int unsigned POS_WIDTH         = 48;
  localparam int unsigned CORDIC_ITERATIONS = 16;

  // CORDIC datapath: Q2.30 vector plus headroom, binary-angle residual
  localparam int unsigned CW         = 34;
  localparam int unsigned ATAN_LEN   = 24;
  localparam int unsigned ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int unsigned ATAN_W     = 30;
  localparam int unsigned CNT_W      = $clog2(CORDIC_ITERATIONS + 1);

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] sin_v;
    logic signed [CW-1:0] cos_v;
  } cordic_res_t;

  // Arctangent of 2^-i in binary-angle units (full turn = 2^32)
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/poi_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface poi_req_if import poi_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_forward;
  logic signed [VEL_W-1:0] vel_lateral;
  logic signed [VEL_W-1:0] yaw_rate;
  logic        [DT_W-1:0]  step_time;

  modport source (output valid, output vel_forward, output vel_lateral, output yaw_rate,
                  output step_time, input ready);
  modport sink   (input valid, input vel_forward, input vel_lateral, input yaw_rate,
                  input step_time, output ready);
endinterface

`default_nettype wire

// File: src/poi_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface poi_rsp_if import poi_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [POSE_W-1:0] pose_x;
  logic signed [POSE_W-1:0] pose_y;
  logic        [ANG_W-1:0]  heading_angle;
  logic signed [QUAT_W-1:0] quat_z;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [VEL_W-1:0]  twist_forward;
  logic signed [VEL_W-1:0]  twist_yaw;

  modport source (output valid, output pose_x, output pose_y, output heading_angle,
                  output quat_z, output quat_w, output twist_forward, output twist_yaw,
                  input ready);
  modport sink   (input valid, input pose_x, input pose_y, input heading_angle,
                  input quat_z, input quat_w, input twist_forward, input twist_yaw,
                  output ready);
endinterface

`default_nettype wire

// File: src/poi_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

// Rotation-mode CORDIC, one micro-rotation per cycle.
module poi_cordic import poi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ANG_W-1:0] angle_i,
  output logic                  done_o,
  output cordic_res_t           res_o
);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 flip_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [CW-1:0] x_d, y_d, z_d;
  logic signed [CW-1:0] xs, ys, at;
  logic                 last;
  logic                 flip_in;
  logic [ANG_W-1:0]     ang_in;
  cordic_res_t          res_q;

  // Fold the left half-plane onto the right one by a half turn
  assign flip_in = angle_i[ANG_W-1] ^ angle_i[ANG_W-2];
  assign ang_in  = {angle_i[ANG_W-1] ^ flip_in, angle_i[ANG_W-2:0]};
  assign last    = (cnt_q == CNT_W'(CORDIC_ITERATIONS));

  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = CW'(atan_lut(ATAN_IDX_W'(cnt_q)));
    if (!z_q[CW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= CW'(signed'(ang_in));
      flip_q <= flip_in;
    end else if (busy_q) begin
      if (last) begin
        res_q.sin_v <= flip_q ? -y_q : y_q;
        res_q.cos_v <= flip_q ? -x_q : x_q;
      end else begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// File: src/planar_odometry_integrator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Planar dead-reckoning odometry integrator. Each request on req_i carries a body-frame
// velocity (forward and lateral in mm/s, yaw rate in mrad/s) and the elapsed time in us.
// The linear velocity is rotated by the heading held before this request, scaled by the
// time step and added with saturation to the stored x/y position (nm); then yaw rate times
// time step is added to the binary-angle heading, which wraps at a full turn. The response
// on rsp_o carries the new pose, the yaw-only quaternion of the new heading in Q1.15 and
// the echoed forward and yaw speeds. Each request passes through two passes of the 16-step
// CORDIC sine/cosine unit, nine steps of the single shared multiplier and the load of the
// output register; req_i is not ready during that time, so a new request is taken only
// after the previous one has been loaded into the output register. A finished response
// sits in an output register, so a new request is taken while the previous response still
// waits on rsp_o; only when that response is still waiting as the next one finishes does
// the block stall. Pose and heading reset to zero.
module planar_odometry_integrator_unit import poi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  poi_req_if.sink   req_i,
  poi_rsp_if.source rsp_o
);

  // Shared multiplier operand and product widths
  localparam int unsigned MA_W      = 37;
  localparam int unsigned MB_W      = 25;
  localparam int unsigned MP_W      = MA_W + MB_W;
  localparam int unsigned SAT_W     = 66;
  localparam int unsigned YAW_FRAC  = 24;
  localparam int unsigned SPD_SHIFT = 16;
  localparam int unsigned DPOS_SHIFT = 14;

  localparam logic signed [MB_W-1:0]  YAW_SCALE_Q24 = 25'sd11468322;
  localparam logic signed [SAT_W-1:0] POS_MAX =
    {{(SAT_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] POS_MIN = -POS_MAX - SAT_W'(1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COR0 = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_COR1 = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // Multiplier schedule; each step after the first also folds in the product of the step before
  typedef enum logic [3:0] {
    MS_FC = 4'd0,  // vf * cos
    MS_LS = 4'd1,  // vl * sin
    MS_FS = 4'd2,  // vf * sin, finish rotated x speed
    MS_LC = 4'd3,  // vl * cos
    MS_XT = 4'd4,  // rx * dt, finish rotated y speed
    MS_YT = 4'd5,  // ry * dt, update x
    MS_WT = 4'd6,  // wz * dt, update y
    MS_WK = 4'd7,  // (wz * dt) * yaw scale
    MS_HD = 4'd8   // update heading
  } mstep_e;

  function automatic logic signed [QUAT_W-1:0] q30_to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    t = ((CW+1)'(v) + (CW+1)'(16384)) >>> 15;
    if (t > (CW+1)'(32767)) begin
      return 16'sh7FFF;
    end else if (t < -(CW+1)'(32768)) begin
      return 16'sh8000;
    end
    return t[QUAT_W-1:0];
  endfunction

  state_e state_q, state_d;
  mstep_e step_q;

  logic signed [VEL_W-1:0] vf_q, vl_q, wz_q;
  logic        [DT_W-1:0]  dt_q;

  logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
  logic        [ANG_W-1:0]     heading_q, heading_d;

  logic signed [MA_W-1:0] mul_a, rx_q, ry_q;
  logic signed [MB_W-1:0] mul_b, dt_s;
  logic signed [MP_W-1:0] prod_q, acc_q;
  logic signed [MP_W:0]   spd_sum;
  logic signed [MP_W-1:0] dpos_r, dpos, head_r;
  logic signed [SAT_W-1:0] pos_sum;
  logic signed [POS_WIDTH-1:0] pos_sel, pos_new;

  logic             cor_start, cor_done;
  logic [ANG_W-1:0] cor_angle;
  cordic_res_t      cor_res;

  logic req_acc, out_load;
  logic signed [63:0] px64, py64;

  logic                     out_valid_q;
  logic signed [POSE_W-1:0] out_px_q, out_py_q;
  logic        [ANG_W-1:0]  out_head_q;
  logic signed [QUAT_W-1:0] out_qz_q, out_qw_q;
  logic signed [VEL_W-1:0]  out_vf_q, out_wz_q;

  poi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .res_o   (cor_res)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || rsp_o.ready);

  // Operand select for the shared multiplier
  assign dt_s = MB_W'(signed'({1'b0, dt_q}));

  always_comb begin
    case (step_q)
      MS_FC:   begin mul_a = MA_W'(cor_res.cos_v); mul_b = MB_W'(vf_q); end
      MS_LS:   begin mul_a = MA_W'(cor_res.sin_v); mul_b = MB_W'(vl_q); end
      MS_FS:   begin mul_a = MA_W'(cor_res.sin_v); mul_b = MB_W'(vf_q); end
      MS_LC:   begin mul_a = MA_W'(cor_res.cos_v); mul_b = MB_W'(vl_q); end
      MS_XT:   begin mul_a = rx_q;                 mul_b = dt_s;        end
      MS_YT:   begin mul_a = ry_q;                 mul_b = dt_s;        end
      MS_WT:   begin mul_a = MA_W'(wz_q);          mul_b = dt_s;        end
      MS_WK:   begin mul_a = prod_q[MA_W-1:0];     mul_b = YAW_SCALE_Q24; end
      default: begin mul_a = '0;                   mul_b = '0;          end
    endcase
  end

  // Rotated speed: round Q30 down to Q14
  always_comb begin
    if (step_q == MS_FS) begin
      spd_sum = (MP_W+1)'(acc_q) - (MP_W+1)'(prod_q) + (MP_W+1)'(32768);
    end else begin
      spd_sum = (MP_W+1)'(acc_q) + (MP_W+1)'(prod_q) + (MP_W+1)'(32768);
    end
  end

  // Position delta in nm and saturating accumulate, shared by x and y
  assign dpos_r  = prod_q + MP_W'(8192);
  assign dpos    = dpos_r >>> DPOS_SHIFT;
  assign pos_sel = (step_q == MS_YT) ? pos_x_q : pos_y_q;
  assign pos_sum = SAT_W'(pos_sel) + SAT_W'(dpos);

  always_comb begin
    if (pos_sum > POS_MAX) begin
      pos_new = POS_MAX[POS_WIDTH-1:0];
    end else if (pos_sum < POS_MIN) begin
      pos_new = POS_MIN[POS_WIDTH-1:0];
    end else begin
      pos_new = pos_sum[POS_WIDTH-1:0];
    end
  end

  // Heading delta: round the Q24 product and wrap
  assign head_r    = prod_q + MP_W'(1 << (YAW_FRAC - 1));
  assign heading_d = heading_q + head_r[YAW_FRAC+ANG_W-1:YAW_FRAC];

  // First pass on the old heading, second on half the new one
  always_comb begin
    cor_start = 1'b0;
    cor_angle = heading_q;
    if (req_acc) begin
      cor_start = 1'b1;
    end else if (state_q == ST_MUL && step_q == MS_HD) begin
      cor_start = 1'b1;
      cor_angle = heading_d >> 1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_acc) state_d = ST_COR0;
      ST_COR0: if (cor_done) state_d = ST_MUL;
      ST_MUL:  if (step_q == MS_HD) state_d = ST_COR1;
      ST_COR1: if (cor_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= MS_FC;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        step_q <= (step_q == MS_HD) ? MS_FC : mstep_e'(step_q + 4'd1);
        if (step_q == MS_YT) pos_x_q <= pos_new;
        if (step_q == MS_WT) pos_y_q <= pos_new;
        if (step_q == MS_HD) heading_q <= heading_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: hold the request, advance the multiplier pipeline
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      vf_q <= req_i.vel_forward;
      vl_q <= req_i.vel_lateral;
      wz_q <= req_i.yaw_rate;
      dt_q <= req_i.step_time;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_b;
      if (step_q == MS_LS || step_q == MS_LC) acc_q <= prod_q;
      if (step_q == MS_FS) rx_q <= spd_sum[MA_W+SPD_SHIFT-1:SPD_SHIFT];
      if (step_q == MS_XT) ry_q <= spd_sum[MA_W+SPD_SHIFT-1:SPD_SHIFT];
    end
  end

  assign px64 = 64'(pos_x_q);
  assign py64 = 64'(pos_y_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_px_q   <= px64[POSE_W-1:0];
      out_py_q   <= py64[POSE_W-1:0];
      out_head_q <= heading_q;
      out_qz_q   <= q30_to_q15(cor_res.sin_v);
      out_qw_q   <= q30_to_q15(cor_res.cos_v);
      out_vf_q   <= vf_q;
      out_wz_q   <= wz_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.pose_x        = out_px_q;
  assign rsp_o.pose_y        = out_py_q;
  assign rsp_o.heading_angle = out_head_q;
  assign rsp_o.quat_z        = out_qz_q;
  assign rsp_o.quat_w        = out_qw_q;
  assign rsp_o.twist_forward = out_vf_q;
  assign rsp_o.twist_yaw     = out_wz_q;

endmodule

`default_nettype wire

// File: bench/planar_odometry_integrator_unit_test.sv
`timescale 1ns / 1ps

module planar_odometry_integrator_unit_test import poi_pkg::*;;

  // Arithmetic constants of the odometry datapath
  localparam int     CORDIC_STEPS    = CORDIC_ITERATIONS;
  localparam longint GAIN_Q30        = 64'sd652032874;
  localparam longint YAW_SCALE_Q24   = 64'sd11468322;
  localparam longint POS_MAX         = 64'sd140737488355327;
  localparam longint POS_MIN         = -64'sd140737488355328;

  // Run control: quiet-cycle limit, settle time at the end, long receiver stall
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PRINT_CAP       = 40;

  typedef struct packed {
    logic [VEL_W-1:0] fwd;
    logic [VEL_W-1:0] lat;
    logic [VEL_W-1:0] yaw;
    logic [DT_W-1:0]  dt;
  } velocity_cmd_t;

  typedef struct packed {
    logic [POSE_W-1:0] x;
    logic [POSE_W-1:0] y;
    logic [ANG_W-1:0]  heading;
    logic [QUAT_W-1:0] qz;
    logic [QUAT_W-1:0] qw;
    logic [VEL_W-1:0]  fwd;
    logic [VEL_W-1:0]  yaw;
  } pose_report_t;

  typedef struct {
    longint sin_v;
    longint cos_v;
  } trig_pair_t;

  // Arctangent of 2^-i as a binary angle, full turn = 2^32
  longint atan_bam [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  poi_req_if cmd_bus ();
  poi_rsp_if pose_bus ();

  planar_odometry_integrator_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cmd_bus),
    .rsp_o (pose_bus)
  );

  // Tracked pose of the integrator, updated once per accepted request
  longint            est_x;
  longint            est_y;
  logic [ANG_W-1:0]  est_heading;
  pose_report_t      pending_poses [$];
  pose_report_t      oldest_pose;

  int error_count;
  int sent_count;
  int checked_count;
  int zero_step_count;
  int limit_hits;
  int left_half_hits;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_off;
  int quiet_cycles;

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pose prediction
  // ---------------------------------------------------------------------------

  // Rotation-mode CORDIC on a binary angle; left half-plane angles are turned by
  // half a turn first and the vector negated afterwards.
  function automatic trig_pair_t cordic_sincos(input logic [ANG_W-1:0] ang);
    longint     x;
    longint     y;
    longint     z;
    longint     xs;
    longint     ys;
    logic [31:0] a;
    bit         flip;
    int         i;
    trig_pair_t r;
    x    = GAIN_Q30;
    y    = 0;
    a    = ang;
    flip = 1'b0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a    = a + 32'h8000_0000;
      flip = 1'b1;
    end
    z = $signed(a);
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_bam[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_bam[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.sin_v = y;
    r.cos_v = x;
    return r;
  endfunction

  // Round Q30 to Q15 and clamp, so +1.0 lands on 32767
  function automatic logic [QUAT_W-1:0] q15_round(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[QUAT_W-1:0];
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Advance the tracked pose by one command and return the pose report it causes
  function automatic pose_report_t integrate_cmd(input velocity_cmd_t cmd);
    longint       f;
    longint       l;
    longint       w;
    longint       d;
    longint       rx;
    longint       ry;
    longint       dh;
    trig_pair_t   t;
    pose_report_t p;
    f  = $signed(cmd.fwd);
    l  = $signed(cmd.lat);
    w  = $signed(cmd.yaw);
    d  = cmd.dt;
    // rotate by the heading held before this step
    t  = cordic_sincos(est_heading);
    rx = (f * t.cos_v - l * t.sin_v + 32768) >>> 16;
    ry = (f * t.sin_v + l * t.cos_v + 32768) >>> 16;
    est_x = clamp_pos(est_x + ((rx * d + 8192) >>> 14));
    est_y = clamp_pos(est_y + ((ry * d + 8192) >>> 14));
    // heading wraps modulo a full turn
    dh = (w * d * YAW_SCALE_Q24 + (64'sd1 <<< 23)) >>> 24;
    est_heading = est_heading + dh[ANG_W-1:0];
    t  = cordic_sincos({1'b0, est_heading[ANG_W-1:1]});
    p.x       = est_x[POSE_W-1:0];
    p.y       = est_y[POSE_W-1:0];
    p.heading = est_heading;
    p.qz      = q15_round(t.sin_v);
    p.qw      = q15_round(t.cos_v);
    p.fwd     = cmd.fwd;
    p.yaw     = cmd.yaw;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic velocity_cmd_t make_cmd(input int f, input int l, input int y,
                                             input int unsigned dt);
    velocity_cmd_t c;
    c.fwd = f[VEL_W-1:0];
    c.lat = l[VEL_W-1:0];
    c.yaw = y[VEL_W-1:0];
    c.dt  = dt[DT_W-1:0];
    return c;
  endfunction

  // Favor the extremes and small values, otherwise the full range
  function automatic logic [VEL_W-1:0] pick_speed();
    logic [VEL_W-1:0] v;
    case ($urandom_range(7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = '0;
      3:       v = 16'($urandom_range(63)) - 16'd32;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    logic [DT_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = '1;
      2:       v = 20'($urandom_range(1, 1000));
      default: v = 20'($urandom);
    endcase
    return v;
  endfunction

  function automatic velocity_cmd_t random_cmd();
    velocity_cmd_t c;
    c.fwd = pick_speed();
    c.lat = pick_speed();
    c.yaw = pick_speed();
    c.dt  = pick_step();
    return c;
  endfunction

  // Offer one request, hold it until accepted, then queue its predicted pose.
  // Called and returns at a rising edge.
  task automatic send_cmd(input velocity_cmd_t cmd);
    pose_report_t want;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.vel_forward <= cmd.fwd;
    cmd_bus.vel_lateral <= cmd.lat;
    cmd_bus.yaw_rate    <= cmd.yaw;
    cmd_bus.step_time   <= cmd.dt;
    @(posedge clk_i);
    while (cmd_bus.ready !== 1'b1) @(posedge clk_i);
    if (est_heading[ANG_W-1] != est_heading[ANG_W-2]) left_half_hits++;
    want = integrate_cmd(cmd);
    pending_poses.push_back(want);
    sent_count++;
    if (cmd.dt == '0) zero_step_count++;
    if (est_x == POS_MAX || est_x == POS_MIN || est_y == POS_MAX || est_y == POS_MIN)
      limit_hits++;
  endtask

  // Drop valid and hold the sender until every pending pose has come back
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_CAP)
      $display("[%0t] response %0d: %s got %h want %h", $realtime, checked_count, what,
               got, want);
    error_count++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want, input int w);
    logic [63:0] mask;
    mask = (64'd1 << w) - 64'd1;
    if (((got ^ want) & mask) !== 64'd0) report_mismatch(what, got & mask, want & mask);
  endtask

  // Compare every accepted response with the oldest pending pose
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && pose_bus.valid === 1'b1 && pose_bus.ready === 1'b1) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("response with no request pending", '0, '0);
      end else begin
        oldest_pose = pending_poses.pop_front();
        compare_field("pose_x", pose_bus.pose_x, oldest_pose.x, POSE_W);
        compare_field("pose_y", pose_bus.pose_y, oldest_pose.y, POSE_W);
        compare_field("heading_angle", pose_bus.heading_angle, oldest_pose.heading, ANG_W);
        compare_field("quat_z", pose_bus.quat_z, oldest_pose.qz, QUAT_W);
        compare_field("quat_w", pose_bus.quat_w, oldest_pose.qw, QUAT_W);
        compare_field("twist_forward", pose_bus.twist_forward, oldest_pose.fwd, VEL_W);
        compare_field("twist_yaw", pose_bus.twist_yaw, oldest_pose.yaw, VEL_W);
        checked_count++;
      end
    end
  end

  // Receiver: a pending hold-off wins, otherwise stall at random per cycle
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      pose_bus.ready <= 1'b0;
      hold_off       <= hold_off - 1;
    end else begin
      pose_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
        (pose_bus.valid === 1'b1 && pose_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d poses pending", quiet_cycles,
               pending_poses.size());
      $display("planar_odometry_integrator_unit_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Drive near full speed along +x and -y with zero yaw straight from reset, so
  // the heading stays at zero (unit quaternion) and both positions grow far
  // beyond 32 bits.
  task automatic test_position_limit();
    repeat (280)
      send_cmd(make_cmd(32767 - int'($urandom_range(15)), -32768 + int'($urandom_range(15)),
                        0, 1048575 - $urandom_range(255)));
    wait_drained();
  endtask

  // Field extremes, zero step, all-ones fields and heading wrap-around
  task automatic test_directed_cases();
    send_cmd(make_cmd(0, 0, 0, 0));
    send_cmd(make_cmd(32767, 32767, 32767, 0));
    send_cmd(make_cmd(-32768, -32768, -32768, 0));
    send_cmd(make_cmd(-32768, 0, 0, 1048575));
    send_cmd(make_cmd(0, 32767, 0, 1048575));
    send_cmd(make_cmd(0, -32768, 0, 1));
    send_cmd(make_cmd(0, 0, 32767, 1048575));
    send_cmd(make_cmd(0, 0, -32768, 1048575));
    send_cmd(make_cmd(-1, -1, -1, 1048575));
    send_cmd(make_cmd(1, 1, 1, 1));
    send_cmd(make_cmd(32767, -32768, 32767, 1048575));
    send_cmd(make_cmd(-32768, 32767, -32768, 1048575));
    send_cmd(make_cmd(32767, 32767, 12000, 500000));
    send_cmd(make_cmd(-32768, -32768, 25000, 700000));
    send_cmd(make_cmd(0, 0, 0, 1048575));
    send_cmd(make_cmd(21845, -21846, -21846, 699050));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) send_cmd(random_cmd());
    wait_drained();
  endtask

  // Stall the receiver for a long stretch while requests keep coming, so the
  // output register fills and the block stops taking requests.
  task automatic test_backpressure();
    int saved_src;
    saved_src    = src_idle_pct;
    src_idle_pct = 0;
    hold_off    <= HOLD_OFF_CYCLES;
    repeat (10) send_cmd(random_cmd());
    wait_drained();
    src_idle_pct = saved_src;
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests (%0d zero-step), %0d responses checked, %0d mismatches",
             sent_count, zero_step_count, checked_count, error_count);
    $display("%0d poses at a position limit, %0d steps from a left half-plane heading",
             limit_hits, left_half_hits);
    if (error_count == 0 && pending_poses.size() == 0) begin
      $display("planar_odometry_integrator_unit_test: done, clean");
    end else begin
      $display("planar_odometry_integrator_unit_test: done, errors");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni              = 1'b0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.vel_forward = '0;
    cmd_bus.vel_lateral = '0;
    cmd_bus.yaw_rate    = '0;
    cmd_bus.step_time   = '0;
    pose_bus.ready      = 1'b0;
    est_x               = 0;
    est_y               = 0;
    est_heading         = '0;
    error_count         = 0;
    sent_count          = 0;
    checked_count       = 0;
    zero_step_count     = 0;
    limit_hits          = 0;
    left_half_hits      = 0;
    hold_off            = 0;
    quiet_cycles        = 0;
    // first phase: sender idles less than the receiver
    src_idle_pct        = 26;
    snk_idle_pct        = 53;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_position_limit();
    test_directed_cases();
    test_random_traffic(250, 26, 53);
    test_backpressure();
    // swap the idle rates, then run with no idling at all
    test_random_traffic(250, 53, 26);
    test_random_traffic(250, 0, 0);
    finish_run();
  end

endmodule

// File: files.f
src/poi_pkg.sv
src/poi_req_if.sv
src/poi_rsp_if.sv
src/poi_cordic.sv
src/planar_odometry_integrator_unit.sv
bench/planar_odometry_integrator_unit_test.sv
